// ===== sv/hnes_pkg.sv =====
// Shared types, codes and helpers for the Hamming nearest-entry search.
// Used by the channel interfaces, the entry cell and the top level.
package hnes_pkg;

    localparam int unsigned ENTRY_W = 6;
    localparam int unsigned LANE_W  = 4;
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned DIST_W  = 11;
    localparam int unsigned POP_W   = 7;

    localparam logic [DIST_W-1:0] DIST_MAX = 11'd2047;

    localparam logic [WORD_W-1:0] M1 = 64'h5555555555555555;
    localparam logic [WORD_W-1:0] M2 = 64'h3333333333333333;
    localparam logic [WORD_W-1:0] M4 = 64'h0F0F0F0F0F0F0F0F;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    // Signals fanned out from the top level to every cell.
    typedef struct packed {
        logic               wr_en;
        logic [ENTRY_W-1:0] wr_entry;
        logic [LANE_W-1:0]  wr_addr;
        logic [WORD_W-1:0]  wr_data;
        logic               rd_en;
        logic [LANE_W-1:0]  rd_addr;
        logic               acc_en;
        logic [WORD_W-1:0]  acc_word;
        logic               clr_en;
        logic [LANE_W-1:0]  clr_addr;
    } t_bcast;

    // Running minimum handed from cell to cell during the answer scan.
    typedef struct packed {
        logic               valid;
        logic               have;
        logic [ENTRY_W-1:0] best;
        logic [DIST_W-1:0]  best_dist;
    } t_tok;

    function automatic logic [POP_W-1:0] popcount64(input logic [WORD_W-1:0] v_in);
        logic [WORD_W-1:0] v;
        logic [POP_W-1:0]  sum;
        v   = v_in - ((v_in >> 1) & M1);
        v   = (v & M2) + ((v >> 2) & M2);
        v   = (v + (v >> 4)) & M4;
        sum = '0;
        for (int b = 0; b < 8; b++) begin
            sum = sum + POP_W'(v[b*8 +: 4]);
        end
        return sum;
    endfunction

endpackage

// ===== sv/hnes_in_if.sv =====
// Input channel of the nearest-entry search: valid/ready plus one item.
// Depends on hnes_pkg for field widths.
interface hnes_in_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [hnes_pkg::ENTRY_W-1:0]  entry;
    logic [hnes_pkg::LANE_W-1:0]   lane;
    logic [hnes_pkg::WORD_W-1:0]   word;
    logic                          final_lane;

    modport source (output valid, op, entry, lane, word, final_lane, input ready);
    modport sink   (input valid, op, entry, lane, word, final_lane, output ready);
endinterface

// ===== sv/hnes_out_if.sv =====
// Result channel of the nearest-entry search: valid/ready plus one answer.
// Depends on hnes_pkg for field widths.
interface hnes_out_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [hnes_pkg::ENTRY_W-1:0]  best_entry;
    logic [hnes_pkg::DIST_W-1:0]   distance;

    modport source (output valid, found, best_entry, distance, input ready);
    modport sink   (input valid, found, best_entry, distance, output ready);
endinterface

// ===== sv/hnes_cell.sv =====
// One entry of the search: its lane memory, valid flag, running distance
// and one stage of the minimum scan. Depends on hnes_pkg.
module hnes_cell #(
    parameter int unsigned LANES    = 16,
    parameter int unsigned CELL_IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hnes_pkg::t_bcast i_bcast,
    input  hnes_pkg::t_tok   i_tok,
    output hnes_pkg::t_tok   o_tok
);

    localparam int unsigned LW = (LANES > 1) ? $clog2(LANES) : 1;

    logic [hnes_pkg::WORD_W-1:0] r_mem [LANES];
    logic [hnes_pkg::WORD_W-1:0] r_rd;
    logic                        r_valid;
    logic [hnes_pkg::DIST_W-1:0] r_acc;
    logic [hnes_pkg::DIST_W-1:0] n_acc;
    hnes_pkg::t_tok              r_tok;
    hnes_pkg::t_tok              n_tok;

    logic                        wr_hit;
    logic [hnes_pkg::POP_W-1:0]  pop;
    logic [hnes_pkg::DIST_W:0]   sum;
    logic                        take;

    assign wr_hit = i_bcast.wr_en &&
                    (i_bcast.wr_entry == hnes_pkg::ENTRY_W'(CELL_IDX));

    always_ff @(posedge i_clk) begin
        if (i_bcast.clr_en) begin
            r_mem[i_bcast.clr_addr[LW-1:0]] <= '0;
        end else if (wr_hit) begin
            r_mem[i_bcast.wr_addr[LW-1:0]] <= i_bcast.wr_data;
        end
        if (i_bcast.rd_en) begin
            r_rd <= r_mem[i_bcast.rd_addr[LW-1:0]];
        end
    end

    assign pop = hnes_pkg::popcount64(i_bcast.acc_word ^ r_rd);
    assign sum = {1'b0, r_acc} + (hnes_pkg::DIST_W + 1)'(pop);

    // The scan token clears the distance as it passes, ready for the next query.
    always_comb begin
        n_acc = r_acc;
        if (i_tok.valid) begin
            n_acc = '0;
        end else if (i_bcast.acc_en) begin
            n_acc = sum[hnes_pkg::DIST_W] ? hnes_pkg::DIST_MAX
                                          : sum[hnes_pkg::DIST_W-1:0];
        end
    end

    assign take = r_valid && (!i_tok.have || (r_acc < i_tok.best_dist));

    always_comb begin
        n_tok = i_tok;
        if (take) begin
            n_tok.have      = 1'b1;
            n_tok.best      = hnes_pkg::ENTRY_W'(CELL_IDX);
            n_tok.best_dist = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_acc   <= '0;
            r_tok   <= '0;
        end else begin
            if (wr_hit) begin
                r_valid <= 1'b1;
            end
            r_acc <= n_acc;
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== sv/hamming_nearest_entry_search.sv =====
// Top level of the Hamming nearest-entry search: input decode, query
// pipeline, the row of hnes_cell instances and the result register.
// Depends on hnes_pkg, hnes_in_if, hnes_out_if and hnes_cell.
//
// Usage: items arrive on i_query (valid/ready). A write item stores one
// 64-bit lane of one entry and marks it valid. A query item presents one
// lane; every entry adds the Hamming distance of that lane to its own
// running total. A query item with final_lane set produces one answer on
// o_result: found flag, nearest valid entry (ties to the lower index) and
// its distance. Writes and non-final query lanes transfer one per cycle.
// After a final lane the answer scan walks the row of cells, one cell per
// cycle, and no new item is taken until the answer has moved into the
// output register. A stalled receiver holds the answer in the output
// register while writes and query lanes keep flowing; the answer of a second
// final lane then waits in a holding register and the input stalls until it
// moves. After reset the lane memories are cleared lane by lane, during
// which ready stays low.
module hamming_nearest_entry_search #(
    parameter int unsigned ENTRIES = 42,
    parameter int unsigned LANES   = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hnes_in_if.sink    i_query,
    hnes_out_if.source o_result
);

    localparam int unsigned LW = (LANES > 1) ? $clog2(LANES) : 1;

    logic                        r_clr_active;
    logic [LW-1:0]               r_clr_cnt;
    logic                        r_busy;
    logic                        r_q_valid;
    logic                        r_q_fin;
    logic [hnes_pkg::WORD_W-1:0] r_q_word;
    logic                        r_start;
    hnes_pkg::t_tok              r_pend;
    logic                        r_out_valid;
    logic                        r_out_found;
    logic [hnes_pkg::ENTRY_W-1:0] r_out_best;
    logic [hnes_pkg::DIST_W-1:0] r_out_dist;

    logic             accept;
    logic             is_query;
    logic             lane_ok;
    logic             move;
    hnes_pkg::t_bcast bcast;
    hnes_pkg::t_tok   w_tok [ENTRIES+1];

    assign i_query.ready = !r_clr_active && !r_busy;
    assign accept   = i_query.valid && i_query.ready;
    assign is_query = (i_query.op == hnes_pkg::OP_QUERY);
    assign lane_ok  = ({1'b0, i_query.lane} < (hnes_pkg::LANE_W + 1)'(LANES));
    assign move     = r_pend.valid && (!r_out_valid || o_result.ready);

    always_comb begin
        bcast          = '0;
        bcast.wr_en    = accept && !is_query && lane_ok;
        bcast.wr_entry = i_query.entry;
        bcast.wr_addr  = i_query.lane;
        bcast.wr_data  = i_query.word;
        bcast.rd_en    = accept && is_query;
        bcast.rd_addr  = i_query.lane;
        bcast.acc_en   = r_q_valid;
        bcast.acc_word = r_q_word;
        bcast.clr_en   = r_clr_active;
        bcast.clr_addr = hnes_pkg::LANE_W'(r_clr_cnt);
    end

    always_comb begin
        w_tok[0]       = '0;
        w_tok[0].valid = r_start;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        hnes_cell #(
            .LANES    (LANES),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bcast (bcast),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q_word <= i_query.word;
        end
        if (move) begin
            r_out_found <= r_pend.have;
            r_out_best  <= r_pend.best;
            r_out_dist  <= r_pend.best_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_cnt    <= '0;
            r_busy       <= 1'b0;
            r_q_valid    <= 1'b0;
            r_q_fin      <= 1'b0;
            r_start      <= 1'b0;
            r_pend       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_clr_active) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == LW'(LANES - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end
            r_q_valid <= accept && is_query && lane_ok;
            r_q_fin   <= accept && is_query && i_query.final_lane;
            r_start   <= r_q_fin;
            // One answer is in flight at a time, so the scan result never
            // meets an occupied holding register.
            if (w_tok[ENTRIES].valid) begin
                r_pend <= w_tok[ENTRIES];
            end else if (move) begin
                r_pend.valid <= 1'b0;
            end
            if (accept && is_query && i_query.final_lane) begin
                r_busy <= 1'b1;
            end else if (move) begin
                r_busy <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.found      = r_out_found;
    assign o_result.best_entry = r_out_best;
    assign o_result.distance   = r_out_dist;

endmodule
